// File: src/pfc_pkg.sv
// shared types and constants for the packet framer with crc-16
// no dependencies

package pfc_pkg;

    localparam logic [7:0]  SYNC_BYTE = 8'h42;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam int          CAP_PAD   = 20;

    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_DEVICE_ADDR = 1'b0;

    typedef enum logic [2:0] {
        PH_HEAD,
        PH_ADDR,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_ID,
        PH_CRC_LO,
        PH_CRC_HI
    } t_phase;

    // one byte through crc-16 xmodem, msb first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c  = crc;
        fb = 1'b0;
        for (int i = 0; i < 8; i++) begin
            fb = c[15] ^ b[7 - i];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

// File: src/packet_framer_crc16_unit.sv
// packet framer top level: header, payload pass-through, crc-16 trailer
// depends on pfc_pkg and pfc_apb_regs
//
// usage
//   input channel (i_valid / o_stall) takes one word per cycle while o_stall is low: a start word
//   (i_op = 0) with packet id and payload length, or a data word (i_op = 1).
//   output channel (o_valid / i_stall) gives the framed bytes one at a time.
//   a start word yields five header bytes, plus two crc bytes when the
//   capped length is zero; a data word yields one byte, plus two crc bytes
//   when it is the last payload byte. data words outside a packet are dropped
//   with no output.
//   an accepted word is held in the input register, and each of its bytes in the output register.
//   throughput: one output byte per cycle while the output is not stalled, set by the
//   single byte-wide crc update between the input register and the output register;
//   payload words stream at one per cycle, a start word holds the input until its
//   five or seven bytes are out. a stalled output holds its byte; the input stalls
//   once the input register holds a word that cannot move on.
//   reset clears the packet state, both channel valids and the device address.
//   device_addr is written over the apb port at byte addresses 0 to 3 (paddr[2] = 0).

module packet_framer_crc16_unit #(
    parameter int MAX_PACKET_BYTES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [7:0]  i_packet_id,
    input  logic [15:0] i_payload_len,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_tx_byte,
    output logic        o_last_of_packet,
    output logic        o_length_capped,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pfc_pkg::*;

    localparam logic [15:0] CAP_LEN = 16'(MAX_PACKET_BYTES - CAP_PAD);

    logic [7:0] device_addr;

    pfc_apb_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_device_addr (device_addr)
    );

    // input word register
    logic        r_iv;
    logic        r_op;
    logic [7:0]  r_id;
    logic [15:0] r_len;
    logic        r_cap;
    logic [7:0]  r_db;
    t_phase      r_phase;
    t_phase      n_phase;

    // framing state
    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic [15:0] r_left;
    logic [15:0] n_left;
    logic        r_inpkt;
    logic        n_inpkt;
    logic        r_cap_seen;
    logic        n_cap_seen;

    // output register
    logic        r_ov;
    logic [7:0]  r_tx;
    logic        r_last;
    logic        r_capd;

    logic        accept_in;
    logic        out_ready;
    logic        data_live;
    logic        drop;
    logic        step;
    logic        emit;
    logic        last_step;
    logic        item_done;
    logic [7:0]  byte_out;
    logic        last_out;
    logic        cap_out;
    logic [15:0] crc_base;
    logic [15:0] crc_next;

    assign out_ready = !r_ov || !i_stall;
    assign data_live = r_inpkt && (r_left != 16'h0000);
    assign drop      = r_iv && (r_op == OP_DATA) && (r_phase == PH_HEAD) && !data_live;
    assign step      = r_iv && (drop || out_ready);
    assign emit      = step && !drop;
    assign item_done = step && last_step;
    assign o_stall   = r_iv && !item_done;
    assign accept_in = i_valid && !o_stall;

    // next phase
    always_comb begin
        n_phase   = r_phase;
        last_step = 1'b0;
        case (r_phase)
            PH_HEAD: begin
                if (r_op == OP_START) begin
                    n_phase = PH_ADDR;
                end else if (!drop && (r_left == 16'h0001)) begin
                    n_phase = PH_CRC_LO;
                end else begin
                    last_step = 1'b1;
                end
            end
            PH_ADDR:   n_phase = PH_LEN_LO;
            PH_LEN_LO: n_phase = PH_LEN_HI;
            PH_LEN_HI: n_phase = PH_ID;
            PH_ID: begin
                if (r_len == 16'h0000) begin
                    n_phase = PH_CRC_LO;
                end else begin
                    last_step = 1'b1;
                end
            end
            PH_CRC_LO: n_phase = PH_CRC_HI;
            PH_CRC_HI: last_step = 1'b1;
            default: begin
                n_phase   = PH_HEAD;
                last_step = 1'b1;
            end
        endcase
    end

    // byte selection per phase
    always_comb begin
        byte_out = r_db;
        last_out = 1'b0;
        case (r_phase)
            PH_HEAD:   byte_out = (r_op == OP_START) ? SYNC_BYTE : r_db;
            PH_ADDR:   byte_out = device_addr;
            PH_LEN_LO: byte_out = r_len[7:0];
            PH_LEN_HI: byte_out = r_len[15:8];
            PH_ID:     byte_out = r_id;
            PH_CRC_LO: byte_out = r_crc[7:0];
            PH_CRC_HI: begin
                byte_out = r_crc[15:8];
                last_out = 1'b1;
            end
            default:   byte_out = r_db;
        endcase
    end

    assign cap_out  = (r_op == OP_START) ? r_cap : r_cap_seen;
    assign crc_base = ((r_op == OP_START) && (r_phase == PH_HEAD)) ? 16'h0000 : r_crc;
    assign crc_next = crc16_byte(crc_base, byte_out);

    // framing state update
    always_comb begin
        n_crc      = r_crc;
        n_left     = r_left;
        n_inpkt    = r_inpkt;
        n_cap_seen = r_cap_seen;
        if (emit) begin
            if ((r_phase != PH_CRC_LO) && (r_phase != PH_CRC_HI)) begin
                n_crc = crc_next;
            end
            if (r_phase == PH_HEAD) begin
                if (r_op == OP_START) begin
                    n_cap_seen = r_cap;
                    n_left     = r_len;
                    n_inpkt    = 1'b1;
                end else begin
                    n_left = r_left - 16'h0001;
                end
            end
            if (r_phase == PH_CRC_HI) begin
                n_inpkt = 1'b0;
                n_left  = 16'h0000;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc      <= 16'h0000;
            r_left     <= 16'h0000;
            r_inpkt    <= 1'b0;
            r_cap_seen <= 1'b0;
        end else begin
            r_crc      <= n_crc;
            r_left     <= n_left;
            r_inpkt    <= n_inpkt;
            r_cap_seen <= n_cap_seen;
        end
    end

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv    <= 1'b0;
            r_phase <= PH_HEAD;
        end else if (accept_in) begin
            r_iv    <= 1'b1;
            r_phase <= PH_HEAD;
        end else if (item_done) begin
            r_iv    <= 1'b0;
            r_phase <= PH_HEAD;
        end else if (step) begin
            r_phase <= n_phase;
        end
    end

    // input register payload, length capped on the way in
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_op <= i_op;
            r_id <= i_packet_id;
            r_db <= i_data_byte;
            if (i_payload_len > CAP_LEN) begin
                r_len <= CAP_LEN;
                r_cap <= 1'b1;
            end else begin
                r_len <= i_payload_len;
                r_cap <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit) begin
            r_ov <= 1'b1;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_tx   <= byte_out;
            r_last <= last_out;
            r_capd <= cap_out;
        end
    end

    assign o_valid          = r_ov;
    assign o_tx_byte        = r_tx;
    assign o_last_of_packet = r_last;
    assign o_length_capped  = r_capd;

endmodule

// File: src/pfc_apb_regs.sv
// apb-style configuration register: device address byte
// depends on pfc_pkg

module pfc_apb_regs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  o_device_addr
);
    import pfc_pkg::*;

    logic [7:0] r_device_addr;
    logic [7:0] n_device_addr;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_DEVICE_ADDR);

    always_comb begin
        n_device_addr = r_device_addr;
        if (wr_en) begin
            n_device_addr = pwdata[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_addr <= 8'h00;
        end else begin
            r_device_addr <= n_device_addr;
        end
    end

    always_comb begin
        prdata = 32'h0000_0000;
        if (paddr[2] == REG_DEVICE_ADDR) begin
            prdata = {24'h00_0000, r_device_addr};
        end
    end

    assign o_device_addr = r_device_addr;

endmodule

// File: tb/sv/packet_framer_crc16_unit_tb.sv
`timescale 1ns / 100ps
// testbench for packet_framer_crc16_unit: drives start and data words, predicts the framed
// byte stream (header, payload, crc-16 xmodem trailer) and checks every byte and flag
// depends on pfc_pkg and the packet_framer_crc16_unit rtl

module packet_framer_crc16_unit_tb;
    import pfc_pkg::*;

    localparam int MAX_BYTES   = 1024;
    localparam int LEN_CAP     = MAX_BYTES - CAP_PAD;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 21;
    localparam logic [2:0] ADDR_DEVICE = {REG_DEVICE_ADDR, 2'b00};
    localparam logic [2:0] ADDR_UNUSED = {~REG_DEVICE_ADDR, 2'b00};

    typedef struct {
        logic [7:0] tx;
        logic       last;
        logic       capped;
    } t_wire_byte;

    typedef struct {
        logic        op;
        logic [7:0]  id;
        logic [15:0] len;
        logic [7:0]  data;
        int          n_out;
        int          capped;
    } t_step_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_op;
    logic [7:0]  i_packet_id;
    logic [15:0] i_payload_len;
    logic [7:0]  i_data_byte;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_tx_byte;
    logic        o_last_of_packet;
    logic        o_length_capped;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    t_wire_byte framed_q[$];

    logic [7:0]  dev_addr_m;
    logic [15:0] crc_m;
    logic [15:0] left_m;
    logic        open_m;
    logic        capped_m;

    logic calm;
    int   errs;
    int   cycles = 0;

    t_step_row directed_rows [16] = '{
        '{OP_DATA,  8'h00, 16'h0000,          8'hFF, 0, -1},  // data while idle
        '{OP_START, 8'h00, 16'h0000,          8'h00, 7,  0},  // empty payload
        '{OP_START, 8'hFF, 16'h0002,          8'h00, 5,  0},
        '{OP_DATA,  8'h00, 16'h0000,          8'h00, 1,  0},
        '{OP_DATA,  8'h00, 16'h0000,          8'hFF, 3,  0},
        '{OP_DATA,  8'h00, 16'h0000,          8'hAA, 0, -1},  // extra byte dropped
        '{OP_START, 8'h5A, 16'hFFFF,          8'h00, 5,  1},
        '{OP_DATA,  8'h00, 16'h0000,          8'h12, 1,  1},
        '{OP_START, 8'hA5, 16'(LEN_CAP + 1),  8'h00, 5,  1},  // restart, one over cap
        '{OP_START, 8'h01, 16'(LEN_CAP),      8'h00, 5,  0},  // exactly at cap
        '{OP_START, 8'h80, 16'h0001,          8'h00, 5,  0},
        '{OP_DATA,  8'h00, 16'h0000,          8'h80, 3,  0},
        '{OP_START, 8'h7F, 16'h0003,          8'h00, 5,  0},
        '{OP_DATA,  8'hFF, 16'hFFFF,          8'h01, 1,  0},
        '{OP_START, 8'h02, 16'h0000,          8'h00, 7,  0},  // restart into empty packet
        '{OP_DATA,  8'h00, 16'h0000,          8'h55, 0, -1}
    };

    packet_framer_crc16_unit #(
        .MAX_PACKET_BYTES(MAX_BYTES)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_op             (i_op),
        .i_packet_id      (i_packet_id),
        .i_payload_len    (i_payload_len),
        .i_data_byte      (i_data_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_tx_byte        (o_tx_byte),
        .o_last_of_packet (o_last_of_packet),
        .o_length_capped  (o_length_capped),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

    function automatic void emit(input logic [7:0] b, input logic last, input logic add);
        if (add) begin
            crc_m = crc16_step(crc_m, b);
        end
        framed_q.push_back('{tx: b, last: last, capped: capped_m});
    endfunction

    function automatic int close_frame();
        emit(crc_m[7:0], 1'b0, 1'b0);
        emit(crc_m[15:8], 1'b1, 1'b0);
        open_m = 1'b0;
        left_m = '0;
        return 2;
    endfunction

    // expected framed bytes for one accepted word, returns how many
    function automatic int frame_predict(input logic op, input logic [7:0] id,
                                         input logic [15:0] len, input logic [7:0] data);
        logic [15:0] eff;
        int          n;
        n = 0;
        if (op == OP_START) begin
            eff      = len;
            capped_m = 1'b0;
            if (len > LEN_CAP) begin
                eff      = 16'(LEN_CAP);
                capped_m = 1'b1;
            end
            crc_m  = '0;
            left_m = eff;
            open_m = 1'b1;
            emit(SYNC_BYTE, 1'b0, 1'b1);
            emit(dev_addr_m, 1'b0, 1'b1);
            emit(eff[7:0], 1'b0, 1'b1);
            emit(eff[15:8], 1'b0, 1'b1);
            emit(id, 1'b0, 1'b1);
            n = 5;
            if (left_m == 0) begin
                n += close_frame();
            end
        end else if (open_m && left_m != 0) begin
            emit(data, 1'b0, 1'b1);
            n      = 1;
            left_m = left_m - 1'b1;
            if (left_m == 0) begin
                n += close_frame();
            end
        end
        return n;
    endfunction

    // entered and left at a falling edge
    task automatic send_word(input logic op, input logic [7:0] id, input logic [15:0] len,
                             input logic [7:0] data, output int n_out);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_op          <= op;
        i_packet_id   <= id;
        i_payload_len <= len;
        i_data_byte   <= data;
        do @(posedge i_clk); while (o_stall);
        n_out = frame_predict(op, id, len, data);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (framed_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_DEVICE) begin
            dev_addr_m = value[7:0];
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read_check();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_DEVICE;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[7:0] !== dev_addr_m) begin
            $display("%0t: device_addr read expected %02h got %02h", $time, dev_addr_m,
                     prdata[7:0]);
            errs++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // mostly well-formed packets, some truncated, overrun or stray data words
    task automatic run_packets(input int n_words);
        int          sent;
        int          body;
        int          eff;
        int          pick;
        int          nn;
        logic [15:0] len;
        sent = 0;
        while (sent < n_words) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_word(1'(OP_DATA), 8'($urandom), 16'($urandom), 8'($urandom), nn);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    len = 16'($urandom);
                end else if (pick < 18) begin
                    len = 16'($urandom_range(13, 120));
                end else begin
                    len = 16'($urandom_range(0, 12));
                end
                send_word(OP_START, 8'($urandom), len, 8'($urandom), nn);
                sent++;
                eff  = (len > LEN_CAP) ? LEN_CAP : int'(len);
                pick = $urandom_range(0, 99);
                if (eff > 120) begin
                    body = $urandom_range(0, 20);
                end else if (pick < 15) begin
                    body = $urandom_range(0, eff);
                end else if (pick < 25) begin
                    body = eff + $urandom_range(1, 3);
                end else begin
                    body = eff;
                end
                repeat (body) begin
                    send_word(OP_DATA, 8'($urandom), 16'($urandom), 8'($urandom), nn);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin : byte_check
        t_wire_byte want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (framed_q.size() == 0) begin
                $display("%0t: byte expected none got %02h last %b capped %b", $time,
                         o_tx_byte, o_last_of_packet, o_length_capped);
                errs++;
            end else begin
                want = framed_q.pop_front();
                if (o_tx_byte !== want.tx) begin
                    $display("%0t: tx_byte expected %02h got %02h", $time, want.tx,
                             o_tx_byte);
                    errs++;
                end
                if (o_last_of_packet !== want.last) begin
                    $display("%0t: last_of_packet expected %b got %b", $time, want.last,
                             o_last_of_packet);
                    errs++;
                end
                if (o_length_capped !== want.capped) begin
                    $display("%0t: length_capped expected %b got %b", $time, want.capped,
                             o_length_capped);
                    errs++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin : stim
        int nn;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_op          = OP_START;
        i_packet_id   = '0;
        i_payload_len = '0;
        i_data_byte   = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        calm          = 1'b0;
        errs          = 0;
        dev_addr_m    = '0;
        crc_m         = '0;
        left_m        = '0;
        open_m        = 1'b0;
        capped_m      = 1'b0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        apb_read_check();

        foreach (directed_rows[r]) begin
            send_word(directed_rows[r].op, directed_rows[r].id, directed_rows[r].len,
                      directed_rows[r].data, nn);
            if (nn != directed_rows[r].n_out) begin
                $display("%0t: row %0d byte count expected %0d got %0d", $time, r,
                         directed_rows[r].n_out, nn);
                errs++;
            end
            if (directed_rows[r].capped >= 0 && capped_m != directed_rows[r].capped[0]) begin
                $display("%0t: row %0d cap flag expected %0d got %b", $time, r,
                         directed_rows[r].capped, capped_m);
                errs++;
            end
        end

        wait_idle();
        apb_write(ADDR_DEVICE, 32'h0000_00FF);
        apb_write(ADDR_UNUSED, $urandom);
        apb_read_check();
        run_packets(80);

        // no idling on either side
        wait_idle();
        apb_write(ADDR_DEVICE, $urandom);
        calm = 1'b1;
        run_packets(80);
        calm = 1'b0;

        wait_idle();
        apb_write(ADDR_DEVICE, 32'h0000_0000);
        run_packets(80);

        wait_idle();
        apb_write(ADDR_DEVICE, $urandom);
        apb_read_check();
        run_packets(80);

        i_valid <= 1'b0;
        while (framed_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errs == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
